// ===== design/lph_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lph_pkg: shared types and constants of the linear probe hash table
// Field widths, status codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package lph_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;

    localparam int SIZE_W   = 11;
    localparam int HOME_W   = 10;
    localparam int KEY_W    = 64;
    localparam int BLK_W    = 10;
    localparam int STATUS_W = 3;

    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 24;

    localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 11'd1024;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_INSERTED  = 3'd0,
        STATUS_FOUND     = 3'd1,
        STATUS_NOT_FOUND = 3'd2,
        STATUS_FULL      = 3'd3,
        STATUS_BAD_SLOT  = 3'd4
    } t_status;

    typedef struct packed {
        logic clear_wr;
        logic accept;
        logic read;
        logic advance;
        logic finish_early;
        logic finish_probe;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic early_done;
        logic probe_done;
        logic out_free;
    } t_dp_stat;

endpackage
`default_nettype wire

// ===== design/lph_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lph_ctrl: request sequencer
// Clears the table after reset, then takes one request at a time through
// the early checks and the probe loop, and hands results to the output.
// ----------------------------------------------------------------------------
module lph_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire lph_pkg::t_dp_stat i_stat,
    output lph_pkg::t_dp_cmd       o_cmd
);
    import lph_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_START = 5'b00100,
        S_READ  = 5'b01000,
        S_CHECK = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_START;
                end
            end
            S_START: begin
                if (i_stat.early_done) begin
                    if (i_stat.out_free) begin
                        o_cmd.finish_early = 1'b1;
                        n_state            = S_IDLE;
                    end
                end else begin
                    o_cmd.read = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.probe_done) begin
                    if (i_stat.out_free) begin
                        o_cmd.finish_probe = 1'b1;
                        n_state            = S_IDLE;
                    end
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_READ;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== design/lph_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lph_datapath: table storage, probe registers and result register
// Holds the slot memory, the size and entry count registers, the request
// being served and the output transaction register.
// ----------------------------------------------------------------------------
module lph_datapath #(
    parameter int TABLE_DEPTH = lph_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire lph_pkg::t_dp_cmd                    i_cmd,
    output lph_pkg::t_dp_stat                        o_stat,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [lph_pkg::SIZE_W-1:0]          i_cfg_wr_data,
    input  wire logic                                i_operation,
    input  wire logic [lph_pkg::HOME_W-1:0]          i_home_slot,
    input  wire logic [lph_pkg::KEY_W-1:0]           i_key_high,
    input  wire logic [lph_pkg::KEY_W-1:0]           i_key_low,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [lph_pkg::STATUS_W-1:0]             o_status,
    output logic [lph_pkg::HOME_W-1:0]               o_slot,
    output logic [lph_pkg::BLK_W-1:0]                o_block_index
);
    import lph_pkg::*;

    localparam int AW       = $clog2(TABLE_DEPTH);
    localparam int CW       = (AW + 1 > SIZE_W) ? AW + 1 : SIZE_W;
    localparam int SIZE_MAX = (1 << SIZE_W) - 1;
    localparam logic [SIZE_W-1:0] SIZE_CAP =
        SIZE_W'((TABLE_DEPTH > SIZE_MAX) ? SIZE_MAX : TABLE_DEPTH);
    localparam int KEY2_W   = 2 * KEY_W;
    localparam int WORD_W   = 1 + BLK_W + KEY2_W;

    logic [WORD_W-1:0] r_mem [TABLE_DEPTH];

    logic [SIZE_W-1:0] r_table_size;
    logic [SIZE_W-1:0] r_count;
    logic [AW-1:0]     r_clr_addr;
    logic              r_op;
    logic [HOME_W-1:0] r_home;
    logic [KEY2_W-1:0] r_key;
    logic [AW-1:0]     r_slot;
    logic [SIZE_W-1:0] r_probe;
    logic              r_rd_occ;
    logic [BLK_W-1:0]  r_rd_blk;
    logic [KEY2_W-1:0] r_rd_key;
    logic              r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [HOME_W-1:0] r_out_slot;
    logic [BLK_W-1:0]  r_out_blk;

    logic [SIZE_W-1:0] size;
    logic              bad_slot;
    logic              ins_full;
    logic              lk_empty;
    logic              key_match;
    logic              last_probe;
    logic [CW-1:0]     slot_inc;
    logic [AW-1:0]     slot_next;
    logic [CW-1:0]     home_cw;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    t_status           early_status;
    t_status           probe_status;
    t_status           res_status;
    logic [HOME_W-1:0] res_slot;
    logic [BLK_W-1:0]  res_blk;

    assign size       = (r_table_size > SIZE_CAP) ? SIZE_CAP : r_table_size;
    assign bad_slot   = {1'b0, r_home} >= size;
    assign ins_full   = !r_op && (r_count >= size);
    assign lk_empty   = r_op && (r_count == '0);
    assign key_match  = r_rd_key == r_key;
    assign last_probe = (r_probe + 1'b1) == size;
    assign slot_inc   = CW'(r_slot) + 1'b1;
    assign slot_next  = (slot_inc == CW'(size)) ? '0 : slot_inc[AW-1:0];
    assign home_cw    = CW'(i_home_slot);

    assign o_stat.clear_last = r_clr_addr == AW'(TABLE_DEPTH - 1);
    assign o_stat.early_done = bad_slot || ins_full || lk_empty;
    assign o_stat.probe_done = !r_rd_occ || (r_op && key_match) || last_probe;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        if (bad_slot) begin
            early_status = STATUS_BAD_SLOT;
        end else if (ins_full) begin
            early_status = STATUS_FULL;
        end else begin
            early_status = STATUS_NOT_FOUND;
        end

        if (!r_rd_occ) begin
            probe_status = r_op ? STATUS_NOT_FOUND : STATUS_INSERTED;
        end else if (r_op && key_match) begin
            probe_status = STATUS_FOUND;
        end else begin
            probe_status = r_op ? STATUS_NOT_FOUND : STATUS_FULL;
        end

        res_status = i_cmd.finish_early ? early_status : probe_status;
        case (res_status)
            STATUS_INSERTED: begin
                res_slot = HOME_W'(r_slot);
                res_blk  = r_count[BLK_W-1:0];
            end
            STATUS_FOUND: begin
                res_slot = HOME_W'(r_slot);
                res_blk  = r_rd_blk;
            end
            default: begin
                res_slot = '0;
                res_blk  = '0;
            end
        endcase
    end

    assign mem_we    = i_cmd.clear_wr ||
                       (i_cmd.finish_probe && !r_op && !r_rd_occ);
    assign mem_waddr = i_cmd.clear_wr ? r_clr_addr : r_slot;
    assign mem_wdata = i_cmd.clear_wr ? '0 :
                       {1'b1, r_count[BLK_W-1:0], r_key};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.read) begin
            {r_rd_occ, r_rd_blk, r_rd_key} <= r_mem[r_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= TABLE_SIZE_RST;
            r_count      <= '0;
            r_clr_addr   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_table_size <= i_cfg_wr_data;
            end
            if (i_cmd.clear_wr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.finish_probe && !r_op && !r_rd_occ) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.finish_early || i_cmd.finish_probe) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= i_operation;
            r_home  <= i_home_slot;
            r_key   <= {i_key_high, i_key_low};
            r_slot  <= home_cw[AW-1:0];
            r_probe <= '0;
        end else if (i_cmd.advance) begin
            r_slot  <= slot_next;
            r_probe <= r_probe + 1'b1;
        end
        if (i_cmd.finish_early || i_cmd.finish_probe) begin
            r_out_status <= res_status;
            r_out_slot   <= res_slot;
            r_out_blk    <= res_blk;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_slot        = r_out_slot;
    assign o_block_index = r_out_blk;

endmodule
`default_nettype wire

// ===== design/linear_probe_hash_table.sv =====
`default_nettype none
// A request settled by the early checks is written to the output register
// from S_START, after the accepting edge; else each probe is one slot memory
// read (S_START or S_READ) and one compare (S_CHECK). A result waiting for the
// output register adds its wait. One request is served at a time. After reset
// a clearing pass writes every slot and empties the table before the first
// request is taken; reset is synchronous.
// ----------------------------------------------------------------------------
// linear_probe_hash_table: open-addressed key table with linear probing
// Inserts 128-bit keys at the first free slot from the home slot, with
// wrap at the table size, and looks keys up along the same probe run.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
    parameter int TABLE_DEPTH = lph_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [lph_pkg::SIZE_W-1:0]        i_cfg_wr_data,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // [9:0] home_slot, [73:10] key_high, [137:74] key_low, rest zero
    input  wire logic [lph_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // [0] operation
    input  wire logic                              i_s_axis_tuser,
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // [2:0] status, [12:3] slot, [22:13] block_index, [23] zero
    output logic [lph_pkg::OUT_DATA_W-1:0]         o_m_axis_tdata
);
    import lph_pkg::*;

    t_dp_cmd             cmd;
    t_dp_stat            stat;
    logic [STATUS_W-1:0] status;
    logic [HOME_W-1:0]   slot;
    logic [BLK_W-1:0]    block_index;

    lph_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    lph_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_operation   (i_s_axis_tuser),
        .i_home_slot   (i_s_axis_tdata[9:0]),
        .i_key_high    (i_s_axis_tdata[73:10]),
        .i_key_low     (i_s_axis_tdata[137:74]),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .o_status      (status),
        .o_slot        (slot),
        .o_block_index (block_index)
    );

    assign o_m_axis_tdata = {1'b0, block_index, slot, status};

endmodule
`default_nettype wire
